### rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
// No dependencies; imported by every module of the block.
package lfu_pkg;

    localparam int DATA_BITS      = 32;
    localparam int CFG_BITS       = 5;
    localparam int LFU_CAPACITY   = 16;
    localparam int LFU_COUNT_BITS = 16;

    localparam logic [CFG_BITS-1:0]  RESET_CAPACITY = CFG_BITS'(16);
    localparam logic [DATA_BITS-1:0] MISS_VALUE     = {DATA_BITS{1'b1}};

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } lfu_op_t;

    typedef struct packed {
        lfu_op_t              opcode;
        logic [DATA_BITS-1:0] lookup_key;
        logic [DATA_BITS-1:0] write_value;
    } lfu_req_t;

    typedef struct packed {
        logic                 hit;
        logic [DATA_BITS-1:0] read_value;
        logic                 evicted;
        logic [DATA_BITS-1:0] evicted_key;
    } lfu_result_t;

endpackage

### rtl/lfu_victim_sel.sv
// Replacement victim search: lowest use count, oldest recency rank wins.
// Binary compare tree over all entries; depends on lfu_pkg.
module lfu_victim_sel
    import lfu_pkg::*;
#(
    parameter int CAPACITY   = LFU_CAPACITY,
    parameter int COUNT_BITS = LFU_COUNT_BITS,
    parameter int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  logic [CAPACITY-1:0]   valid,
    input  logic [COUNT_BITS-1:0] count [CAPACITY],
    input  logic [IDX_BITS-1:0]   rank  [CAPACITY],
    output logic                  found,
    output logic [IDX_BITS-1:0]   victim_idx
);

    localparam int LEAVES = 1 << IDX_BITS;

    logic                  node_vld  [2*LEAVES];
    logic [COUNT_BITS-1:0] node_cnt  [2*LEAVES];
    logic [IDX_BITS-1:0]   node_rank [2*LEAVES];
    logic [IDX_BITS-1:0]   node_idx  [2*LEAVES];

    always_comb
    begin
        logic right_wins;
        right_wins = 1'b0;
        for (int i = 0; i < 2*LEAVES; i++)
        begin
            node_vld[i]  = 1'b0;
            node_cnt[i]  = '0;
            node_rank[i] = '0;
            node_idx[i]  = '0;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            node_vld[LEAVES+i]  = valid[i];
            node_cnt[LEAVES+i]  = count[i];
            node_rank[LEAVES+i] = rank[i];
            node_idx[LEAVES+i]  = IDX_BITS'(i);
        end
        // Parent n compares children 2n (lower indices) and 2n+1.
        for (int n = LEAVES - 1; n >= 1; n--)
        begin
            right_wins = node_vld[2*n+1] &&
                         (!node_vld[2*n] ||
                          (node_cnt[2*n+1] < node_cnt[2*n]) ||
                          ((node_cnt[2*n+1] == node_cnt[2*n]) &&
                           (node_rank[2*n+1] > node_rank[2*n])));
            if (right_wins)
            begin
                node_vld[n]  = node_vld[2*n+1];
                node_cnt[n]  = node_cnt[2*n+1];
                node_rank[n] = node_rank[2*n+1];
                node_idx[n]  = node_idx[2*n+1];
            end
            else
            begin
                node_vld[n]  = node_vld[2*n];
                node_cnt[n]  = node_cnt[2*n];
                node_rank[n] = node_rank[2*n];
                node_idx[n]  = node_idx[2*n];
            end
        end
    end

    assign found      = node_vld[1];
    assign victim_idx = node_idx[1];

endmodule

### rtl/lfu_table.sv
// Entry storage, parallel key match and per-request table update.
// Depends on lfu_pkg and lfu_victim_sel.
module lfu_table
    import lfu_pkg::*;
#(
    parameter int CAPACITY   = LFU_CAPACITY,
    parameter int COUNT_BITS = LFU_COUNT_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  lfu_req_t            req,
    input  logic [CFG_BITS-1:0] active_capacity,
    output lfu_result_t         result
);

    localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_BITS  = $clog2(CAPACITY + 1);
    localparam int UW        = (OCC_BITS > CFG_BITS) ? OCC_BITS : CFG_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [CAPACITY-1:0]   valid_reg, valid_next;
    logic [DATA_BITS-1:0]  key_reg   [CAPACITY];
    logic [DATA_BITS-1:0]  key_next  [CAPACITY];
    logic [DATA_BITS-1:0]  value_reg [CAPACITY];
    logic [DATA_BITS-1:0]  value_next[CAPACITY];
    logic [COUNT_BITS-1:0] count_reg [CAPACITY];
    logic [COUNT_BITS-1:0] count_next[CAPACITY];
    logic [IDX_BITS-1:0]   rank_reg  [CAPACITY];
    logic [IDX_BITS-1:0]   rank_next [CAPACITY];

    logic                hit;
    logic [IDX_BITS-1:0] match_idx;
    logic                free_found;
    logic [IDX_BITS-1:0] free_idx;
    logic                victim_found;
    logic [IDX_BITS-1:0] victim_idx;
    logic [UW-1:0]       used;
    logic [UW-1:0]       cap_eff;
    logic                is_put;
    logic                do_bump;
    logic                do_insert;
    logic                do_evict;
    logic [IDX_BITS-1:0] slot;
    logic [IDX_BITS-1:0] match_rank;
    logic [IDX_BITS-1:0] victim_rank;

    lfu_victim_sel #(
        .CAPACITY   (CAPACITY),
        .COUNT_BITS (COUNT_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_victim (
        .valid      (valid_reg),
        .count      (count_reg),
        .rank       (rank_reg),
        .found      (victim_found),
        .victim_idx (victim_idx)
    );

    // Lowest matching entry and lowest free entry
    always_comb
    begin
        hit        = 1'b0;
        match_idx  = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (key_reg[i] == req.lookup_key))
            begin
                hit       = 1'b1;
                match_idx = IDX_BITS'(i);
            end
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_BITS'(i);
            end
        end
    end

    assign used    = UW'($countones(valid_reg));
    assign cap_eff = (UW'(active_capacity) > UW'(CAPACITY)) ? UW'(CAPACITY)
                                                            : UW'(active_capacity);
    assign is_put  = (req.opcode == OP_PUT);

    assign do_bump   = req_valid && hit && (!is_put || (cap_eff != '0));
    assign do_insert = req_valid && is_put && !hit && (cap_eff != '0);
    assign do_evict  = do_insert && (used >= cap_eff) && victim_found;
    assign slot      = (do_evict && (!free_found || (victim_idx < free_idx)))
                       ? victim_idx : free_idx;

    assign match_rank  = rank_reg[match_idx];
    assign victim_rank = rank_reg[victim_idx];

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_next[i]   = key_reg[i];
            value_next[i] = value_reg[i];
            count_next[i] = count_reg[i];
            rank_next[i]  = rank_reg[i];

            if (do_bump)
            begin
                if (IDX_BITS'(i) == match_idx)
                begin
                    rank_next[i] = '0;
                    if (count_reg[i] != COUNT_MAX)
                        count_next[i] = count_reg[i] + 1'b1;
                    if (is_put)
                        value_next[i] = req.write_value;
                end
                else if (valid_reg[i] && (rank_reg[i] < match_rank))
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end

            if (do_insert)
            begin
                if (IDX_BITS'(i) == slot)
                begin
                    valid_next[i] = 1'b1;
                    key_next[i]   = req.lookup_key;
                    value_next[i] = req.write_value;
                    count_next[i] = COUNT_BITS'(1);
                    rank_next[i]  = '0;
                end
                else if (do_evict && (IDX_BITS'(i) == victim_idx))
                begin
                    valid_next[i] = 1'b0;
                end
                else if (valid_reg[i])
                begin
                    // close the victim's gap, then age behind the new entry
                    if (do_evict && (rank_reg[i] > victim_rank))
                        rank_next[i] = rank_reg[i];
                    else
                        rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.hit         = hit;
        result.evicted     = do_evict;
        result.evicted_key = do_evict ? key_reg[victim_idx] : '0;
        if (is_put)
            result.read_value = '0;
        else if (hit)
            result.read_value = value_reg[match_idx];
        else
            result.read_value = MISS_VALUE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (req_valid)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                key_reg[i]   <= key_next[i];
                value_reg[i] <= value_next[i];
                count_reg[i] <= count_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> valid_reg[$past(slot)])
        else $error("inserted entry not valid");

    a_evict_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        do_evict |=> ($countones(valid_reg) == $past($countones(valid_reg))))
        else $error("eviction changed occupancy");

    a_bump_newest: assert property (@(posedge clk) disable iff (!rst_n)
        do_bump |=> (rank_reg[$past(match_idx)] == '0))
        else $error("touched entry not most recent");
`endif

endmodule

### rtl/lfu_cache_table_top.sv
// Top level of the LFU cache table: stream ports, input and result registers.
// Depends on lfu_pkg and lfu_table.
//
// Usage:
//   Requests arrive on the s_axis channel, one item per get or put. tuser
//   carries the opcode (get or put); tdata carries the key and, for a put,
//   the value. Each request yields exactly one result item on m_axis: tuser
//   holds the hit and evicted flags, tdata the read value and evicted key.
//   active_capacity is written through cfg_wr_en/cfg_wr_data, by the user only
//   while no request is in flight, unchecked; larger values act as CAPACITY.
// Timing:
//   A request is held in an input register, then the whole lookup, victim
//   search and table update happen combinationally between that register and
//   the result register, which drives tvalid.
//   One item per cycle is sustained while m_axis_tready stays high; the bound
//   is the combinational compare tree across all CAPACITY entries.
// Reset:
//   rst_n clears the table (all entries free), empties both registers and
//   sets active_capacity to 16.
// Back-pressure:
//   When m_axis_tready is low the result holds; the input register still
//   takes one more item, after which s_axis_tready drops until space frees.
module lfu_cache_table_top
    import lfu_pkg::*;
#(
    parameter int CAPACITY   = LFU_CAPACITY,
    parameter int COUNT_BITS = LFU_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [2*DATA_BITS-1:0] s_axis_tdata,  // lookup_key, write_value
    input  logic                  s_axis_tuser,  // opcode

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [2*DATA_BITS-1:0] m_axis_tdata,  // read_value, evicted_key
    output logic [1:0]            m_axis_tuser,  // hit, evicted

    input  logic                  cfg_wr_en,
    input  logic [CFG_BITS-1:0]   cfg_wr_data    // active_capacity
);

    logic                in_valid_reg;
    lfu_req_t            in_req_reg;
    logic                out_valid_reg;
    lfu_result_t         out_res_reg;
    logic [CFG_BITS-1:0] cap_reg;
    lfu_result_t         table_res;
    logic                advance;

    // The held request is processed when the result register has room.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= RESET_CAPACITY;
        else if (cfg_wr_en)
            cap_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_req_reg.opcode      <= lfu_op_t'(s_axis_tuser);
            in_req_reg.lookup_key  <= s_axis_tdata[DATA_BITS-1:0];
            in_req_reg.write_value <= s_axis_tdata[2*DATA_BITS-1:DATA_BITS];
        end
    end

    lfu_table #(
        .CAPACITY   (CAPACITY),
        .COUNT_BITS (COUNT_BITS)
    ) u_table (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (advance),
        .req             (in_req_reg),
        .active_capacity (cap_reg),
        .result          (table_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= table_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.evicted_key, out_res_reg.read_value};
    assign m_axis_tuser  = {out_res_reg.evicted, out_res_reg.hit};

endmodule
